[hdl/slr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

	localparam int TIME_BITS  = 16;
	localparam int ANGLE_BITS = 8;
	localparam int PROD_BITS  = ANGLE_BITS + TIME_BITS;
	localparam int STEP_BITS  = $clog2(ANGLE_BITS);

	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	localparam logic [ANGLE_BITS-1:0] RESET_ANGLE = ANGLE_BITS'(90);

	// register index taken from the word address bit
	localparam logic REG_INITIAL_ANGLE = 1'b0;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_MOVE = 2'd1,
		CMD_JUMP = 2'd2,
		CMD_NONE = 2'd3
	} slr_cmd_t;

	typedef struct packed {
		logic                  wr;
		logic [ANGLE_BITS-1:0] value;
	} slr_cfg_t;

	typedef struct packed {
		logic                  start;
		logic [ANGLE_BITS-1:0] mag;
		logic [TIME_BITS-1:0]  factor;
		logic [TIME_BITS-1:0]  divisor;
	} slr_md_req_t;

	typedef struct packed {
		logic                  done;
		logic [ANGLE_BITS-1:0] quot;
	} slr_md_rsp_t;

endpackage

`default_nettype wire

[hdl/slr_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface slr_cmd_if import slr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	logic [ANGLE_BITS-1:0] target_angle;
	logic [15:0]           move_time;

	modport source (output valid, command, target_angle, move_time, input ready);
	modport sink   (input valid, command, target_angle, move_time, output ready);
endinterface

`default_nettype wire

[hdl/slr_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface slr_res_if import slr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] angle;
	logic                  servo_write;
	logic                  moving;

	modport source (output valid, angle, servo_write, moving, input ready);
	modport sink   (input valid, angle, servo_write, moving, output ready);
endinterface

`default_nettype wire

[hdl/slr_apb.sv]
`timescale 1ns / 1ps
`default_nettype none

module slr_apb import slr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	output logic      [PDATA_BITS-1:0] prdata,
	output logic                       pready,
	output slr_cfg_t                   cfg
);

	logic [ANGLE_BITS-1:0] initial_q;
	logic                  hit;

	assign hit        = paddr[PADDR_BITS-1] == REG_INITIAL_ANGLE;
	assign pready     = 1'b1;
	assign cfg.wr     = psel && penable && pwrite && hit;
	assign cfg.value  = pwdata[ANGLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_q <= RESET_ANGLE;
		end else if (cfg.wr) begin
			initial_q <= cfg.value;
		end
	end

	assign prdata = hit ? PDATA_BITS'(initial_q) : '0;

endmodule

`default_nettype wire

[hdl/slr_muldiv.sv]
`timescale 1ns / 1ps
`default_nettype none

// shift-add multiply, one bit of mag per cycle, then restoring divide,
// one quotient bit per cycle, in the same accumulator
module slr_muldiv import slr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  slr_md_req_t      req,
	output slr_md_rsp_t      rsp
);

	logic                  busy_q;
	logic                  div_q;
	logic                  done_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [ANGLE_BITS-1:0] mag_q;
	logic [TIME_BITS-1:0]  fac_q;
	logic [TIME_BITS-1:0]  dvs_q;
	logic [PROD_BITS-1:0]  acc_q;

	logic [PROD_BITS-1:0]  mul_next;
	logic [TIME_BITS:0]    trial;
	logic                  qbit;
	logic [TIME_BITS-1:0]  rem_next;
	logic                  last_step;

	assign last_step = step_q == STEP_BITS'(ANGLE_BITS - 1);

	always_comb begin
		mul_next = {acc_q[PROD_BITS-2:0], 1'b0}
			+ (mag_q[ANGLE_BITS-1] ? PROD_BITS'(fac_q) : '0);
		trial    = {acc_q[PROD_BITS-1:ANGLE_BITS], acc_q[ANGLE_BITS-1]};
		qbit     = trial >= {1'b0, dvs_q};
		rem_next = qbit ? TIME_BITS'(trial - {1'b0, dvs_q}) : trial[TIME_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= 1'b0;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					step_q <= '0;
					if (div_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						div_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.mag;
			fac_q <= req.factor;
			dvs_q <= req.divisor;
			acc_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				acc_q <= {rem_next, acc_q[ANGLE_BITS-2:0], qbit};
			end else begin
				acc_q <= mul_next;
				mag_q <= {mag_q[ANGLE_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q[ANGLE_BITS-1:0];

endmodule

`default_nettype wire

[hdl/servo_linear_ramp_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// start move, jump, idle tick, final ramp tick, unused code: beat in the cycle after accept
// a ramp tick gives its beat after 8 multiply and 8 divide steps in
// slr_muldiv, once the quotient is taken and ST_EMIT can load the output register
// throughput: one command in flight at a time, so a ramp tick holds the input until its beat
// is loaded; other commands can follow every cycle while the result side takes its beats
// reset: asynchronous, active low; angle and initial_angle return to 90, move state idle
module servo_linear_ramp_core import slr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	output logic      [PDATA_BITS-1:0] prdata,
	output logic                       pready,
	slr_cmd_if.sink                    cmd,
	slr_res_if.source                  res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_EMIT = 3'b100
	} slr_state_t;

	slr_state_t            state_q;
	logic [ANGLE_BITS-1:0] present_q;
	logic [ANGLE_BITS-1:0] origin_q;
	logic [ANGLE_BITS-1:0] goal_q;
	logic [TIME_BITS-1:0]  span_q;
	logic [TIME_BITS-1:0]  elapsed_q;
	logic                  motion_q;
	logic                  no_cmd_q;
	logic                  out_valid_q;
	logic [ANGLE_BITS-1:0] out_angle_q;
	logic                  out_write_q;
	logic                  out_moving_q;

	slr_cfg_t              cfg;
	slr_md_req_t           md_req;
	slr_md_rsp_t           md_rsp;

	logic                  out_free;
	logic                  in_fire;
	logic                  up;
	logic [TIME_BITS-1:0]  el_next;
	logic [TIME_BITS-1:0]  dur;
	logic                  tick_end;
	logic [ANGLE_BITS-1:0] ramp_angle;
	logic                  load_out;
	logic [ANGLE_BITS-1:0] out_angle_d;
	logic                  out_write_d;
	logic                  out_moving_d;
	slr_cmd_t              op;

	slr_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign out_free  = !out_valid_q || res.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign in_fire   = cmd.valid && cmd.ready;
	assign op        = slr_cmd_t'(cmd.command);

	assign up         = goal_q >= origin_q;
	assign el_next    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign dur        = TIME_BITS'(cmd.move_time);
	assign tick_end   = el_next >= span_q;
	assign ramp_angle = up ? origin_q + md_rsp.quot : origin_q - md_rsp.quot;

	assign md_req.mag     = up ? goal_q - origin_q : origin_q - goal_q;
	assign md_req.factor  = el_next;
	assign md_req.divisor = span_q;

	always_comb begin
		load_out     = 1'b0;
		md_req.start = 1'b0;
		out_angle_d  = present_q;
		out_write_d  = 1'b0;
		out_moving_d = motion_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (op)
						CMD_TICK: begin
							if (motion_q && !tick_end) begin
								md_req.start = 1'b1;
							end else if (motion_q) begin
								load_out     = 1'b1;
								out_angle_d  = goal_q;
								out_write_d  = 1'b1;
								out_moving_d = 1'b0;
							end else begin
								load_out = 1'b1;
							end
						end
						CMD_MOVE: begin
							load_out     = 1'b1;
							out_moving_d = 1'b1;
						end
						CMD_JUMP: begin
							load_out     = 1'b1;
							out_angle_d  = cmd.target_angle;
							out_write_d  = 1'b1;
							out_moving_d = 1'b0;
						end
						CMD_NONE: begin
							load_out = 1'b1;
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_CALC: begin
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out     = 1'b1;
					out_write_d  = 1'b1;
					out_moving_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			present_q   <= RESET_ANGLE;
			origin_q    <= '0;
			goal_q      <= '0;
			span_q      <= '0;
			elapsed_q   <= '0;
			motion_q    <= 1'b0;
			no_cmd_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			// before the first tick, move or jump command the register also sets the held angle
			if (cfg.wr && no_cmd_q) begin
				present_q <= cfg.value;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (op)
							CMD_TICK: begin
								no_cmd_q <= 1'b0;
								if (motion_q) begin
									elapsed_q <= el_next;
									if (tick_end) begin
										present_q <= goal_q;
										motion_q  <= 1'b0;
									end else begin
										state_q <= ST_CALC;
									end
								end
							end
							CMD_MOVE: begin
								no_cmd_q  <= 1'b0;
								origin_q  <= present_q;
								goal_q    <= cmd.target_angle;
								span_q    <= dur;
								elapsed_q <= '0;
								motion_q  <= 1'b1;
							end
							CMD_JUMP: begin
								no_cmd_q  <= 1'b0;
								present_q <= cmd.target_angle;
								motion_q  <= 1'b0;
							end
							CMD_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_CALC: begin
					if (md_rsp.done) begin
						present_q <= ramp_angle;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_angle_q  <= out_angle_d;
			out_write_q  <= out_write_d;
			out_moving_q <= out_moving_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.angle       = out_angle_q;
	assign res.servo_write = out_write_q;
	assign res.moving      = out_moving_q;

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> state_q == ST_CALC)
		else $error("divider finished outside a ramp tick");

	a_ramp_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |->
			((up && present_q >= origin_q && present_q <= goal_q) ||
			 (!up && present_q <= origin_q && present_q >= goal_q)))
		else $error("ramp angle outside origin and goal");

	a_jump_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == CMD_JUMP) |=> (res.valid && res.servo_write && !res.moving))
		else $error("jump did not give a write beat");

endmodule

`default_nettype wire

[tb/sv/servo_ramp_checker.sv]
`timescale 1ns / 1ps

module servo_ramp_checker import slr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic                  pready,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	slr_cmd_if                         cmd,
	slr_res_if                         res,
	output int                         pending,
	output int                         fails
);

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle;
		logic                  servo_write;
		logic                  moving;
	} servo_beat_t;

	servo_beat_t due_beats[$];

	logic [ANGLE_BITS-1:0] home_angle;
	logic [ANGLE_BITS-1:0] cur_angle;
	logic [ANGLE_BITS-1:0] from_angle;
	logic [ANGLE_BITS-1:0] to_angle;
	logic [TIME_BITS-1:0]  span_ms;
	logic [TIME_BITS-1:0]  elapsed_ms;
	logic                  running;
	logic                  untouched;

	// point on the line from origin to goal, truncated towards the origin
	function automatic logic [ANGLE_BITS-1:0] ramp_angle();
		logic [ANGLE_BITS-1:0] delta;
		logic [PROD_BITS-1:0]  prod;
		logic [ANGLE_BITS-1:0] step;
		delta = (to_angle >= from_angle) ? to_angle - from_angle : from_angle - to_angle;
		prod = PROD_BITS'(delta) * PROD_BITS'(elapsed_ms);
		step = ANGLE_BITS'(prod / PROD_BITS'(span_ms));
		return (to_angle >= from_angle) ? from_angle + step : from_angle - step;
	endfunction

	function automatic servo_beat_t apply_servo_command(slr_cmd_t code,
			logic [ANGLE_BITS-1:0] tgt, logic [15:0] dur);
		servo_beat_t beat;
		beat.servo_write = 1'b0;
		case (code)
			CMD_MOVE: begin
				untouched  = 1'b0;
				from_angle = cur_angle;
				to_angle   = tgt;
				span_ms    = TIME_BITS'(dur);
				elapsed_ms = '0;
				running    = 1'b1;
			end
			CMD_JUMP: begin
				untouched        = 1'b0;
				cur_angle        = tgt;
				running          = 1'b0;
				beat.servo_write = 1'b1;
			end
			CMD_TICK: begin
				untouched = 1'b0;
				if (running) begin
					if (elapsed_ms != '1)
						elapsed_ms = elapsed_ms + 1'b1;
					if (elapsed_ms >= span_ms) begin
						cur_angle = to_angle;
						running   = 1'b0;
					end else begin
						cur_angle = ramp_angle();
					end
					beat.servo_write = 1'b1;
				end
			end
			default: ;
		endcase
		beat.angle  = cur_angle;
		beat.moving = running;
		return beat;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		servo_beat_t want;
		int          errs;
		errs = 0;
		if (!arst_n) begin
			home_angle = RESET_ANGLE;
			cur_angle  = RESET_ANGLE;
			from_angle = '0;
			to_angle   = '0;
			span_ms    = '0;
			elapsed_ms = '0;
			running    = 1'b0;
			untouched  = 1'b1;
			due_beats.delete();
			pending <= 0;
			fails   <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_INITIAL_ANGLE) begin
				home_angle = pwdata[ANGLE_BITS-1:0];
				// only takes effect on the angle until the first tick, move or jump command
				if (untouched)
					cur_angle = home_angle;
			end
			if (cmd.valid && cmd.ready)
				due_beats.push_back(apply_servo_command(slr_cmd_t'(cmd.command),
					cmd.target_angle, cmd.move_time));
			if (res.valid && res.ready) begin
				if (due_beats.size() == 0) begin
					$error("result beat with nothing expected: angle %0d", res.angle);
					errs++;
				end else begin
					want = due_beats.pop_front();
					if (res.angle !== want.angle) begin
						$error("angle: expected %0d, got %0d", want.angle, res.angle);
						errs++;
					end
					if (res.servo_write !== want.servo_write) begin
						$error("servo_write: expected %0d, got %0d", want.servo_write,
							res.servo_write);
						errs++;
					end
					if (res.moving !== want.moving) begin
						$error("moving: expected %0d, got %0d", want.moving, res.moving);
						errs++;
					end
				end
			end
			fails   <= fails + errs;
			pending <= due_beats.size();
		end
	end

endmodule

[tb/sv/servo_linear_ramp_core_tb.sv]
`timescale 1ns / 1ps

module servo_linear_ramp_core_tb import slr_pkg::*; ();

	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_ITEMS  = 445;
	localparam int SETTLE_TICKS = 25;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [PDATA_BITS-1:0] pwdata;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	int pending;
	int fails;
	int cycles;
	int sent;
	bit send_calm;
	bit recv_calm;

	slr_cmd_if cmd_ch ();
	slr_res_if res_ch ();

	servo_linear_ramp_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	servo_ramp_checker checker_i (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.pready (pready),
		.paddr  (paddr),
		.pwdata (pwdata),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.pending(pending),
		.fails  (fails)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_initial_angle(logic [ANGLE_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_INITIAL_ANGLE, 2'b00};
		pwdata  <= PDATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic put_cmd(slr_cmd_t code, logic [ANGLE_BITS-1:0] tgt, logic [15:0] dur);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= code;
		cmd_ch.target_angle <= tgt;
		cmd_ch.move_time    <= dur;
		do @(posedge clk); while (!cmd_ch.ready);
		sent++;
		if (sent % 64 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic put_tick();
		put_cmd(CMD_TICK, ANGLE_BITS'($urandom), 16'($urandom));
	endtask

	// stop offering and let the block finish everything in flight
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	function automatic logic [ANGLE_BITS-1:0] pick_angle();
		if ($urandom_range(0, 9) == 0)
			return ANGLE_BITS'($urandom_range(181, 255));
		return ANGLE_BITS'($urandom_range(0, 180));
	endfunction

	// mostly a move followed by a run of ticks, the rest jumps and random commands
	task automatic ramp_sequence();
		logic [15:0] span;
		int          pick;
		int          n;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			pick = $urandom_range(0, 19);
			if (pick < 15)
				span = 16'($urandom_range(0, 24));
			else if (pick < 19)
				span = 16'($urandom_range(25, 3000));
			else
				span = 16'($urandom);
			put_cmd(CMD_MOVE, pick_angle(), span);
			if (span < 40 && $urandom_range(0, 2) != 0)
				n = span + $urandom_range(1, 3);
			else
				n = $urandom_range(0, 30);
			repeat (n) put_tick();
		end else if (pick < 88) begin
			put_cmd(CMD_JUMP, pick_angle(), 16'($urandom));
		end else begin
			put_cmd(slr_cmd_t'($urandom_range(0, 3)), ANGLE_BITS'($urandom),
				16'($urandom));
		end
	endtask

	initial begin
		int stall;
		int beats;
		beats = 0;
		res_ch.ready <= 1'b0;
		forever begin
			// two long hold-offs so the block backs up into its input
			if (beats == 250 || beats == 1200)
				stall = 400;
			else
				stall = recv_calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			beats++;
			if (beats % 50 == 0)
				recv_calm = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int phase;
		sent                 = 0;
		send_calm            = 1'b0;
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.command      <= CMD_TICK;
		cmd_ch.target_angle <= '0;
		cmd_ch.move_time    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both writes land on the angle since no command has come yet
		write_initial_angle(ANGLE_BITS'(0));
		write_initial_angle(ANGLE_BITS'(180));

		put_tick();
		put_cmd(CMD_NONE, 8'hff, 16'hffff);
		put_cmd(CMD_JUMP, 8'd0, 16'h0000);
		put_cmd(CMD_MOVE, 8'd180, 16'd0);
		put_tick();
		put_cmd(CMD_MOVE, 8'd0, 16'd4);
		repeat (4) put_tick();
		put_tick();
		put_cmd(CMD_JUMP, 8'hff, 16'h5a5a);
		put_cmd(CMD_MOVE, 8'd0, 16'd3);
		repeat (2) put_tick();
		// restart from wherever the ramp has got to
		put_cmd(CMD_MOVE, 8'd180, 16'hffff);
		repeat (3) put_tick();
		put_cmd(CMD_NONE, 8'h00, 16'h0000);
		put_cmd(CMD_JUMP, 8'd180, 16'ha5a5);
		put_cmd(CMD_MOVE, 8'hff, 16'd1);
		put_tick();
		put_cmd(CMD_MOVE, 8'd7, 16'hffff);
		put_tick();
		put_cmd(CMD_JUMP, 8'd90, 16'h0000);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			if (phase == 1)
				write_initial_angle(ANGLE_BITS'(0));
			else if (phase == 3)
				write_initial_angle(ANGLE_BITS'(180));
			else
				write_initial_angle(ANGLE_BITS'($urandom_range(0, 180)));
			while (sent < 25 + (phase + 1) * PHASE_ITEMS)
				ramp_sequence();
			drain();
		end

		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
